[design/lc3x_pkg.sv]
// ----------------------------------------------------------------------------
// lc3x_pkg
// Shared constants and types for the LC-3 execute block.
// ----------------------------------------------------------------------------
package lc3x_pkg;

   localparam int unsigned AddrBitsDefault = 16;
   localparam logic [15:0] StartPcReset    = 16'h3000;

   localparam logic [1:0] CMD_WRITE   = 2'd0;
   localparam logic [1:0] CMD_STEP    = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   localparam logic [1:0] RUN_GO      = 2'd0;
   localparam logic [1:0] RUN_HALTED  = 2'd1;
   localparam logic [1:0] RUN_INVALID = 2'd2;

   localparam logic [1:0] STR_IDLE  = 2'd0;
   localparam logic [1:0] STR_PUTS  = 2'd1;
   localparam logic [1:0] STR_PUTSP = 2'd2;

   localparam logic [3:0] OP_BR   = 4'd0;
   localparam logic [3:0] OP_ADD  = 4'd1;
   localparam logic [3:0] OP_LD   = 4'd2;
   localparam logic [3:0] OP_ST   = 4'd3;
   localparam logic [3:0] OP_JSR  = 4'd4;
   localparam logic [3:0] OP_AND  = 4'd5;
   localparam logic [3:0] OP_LDR  = 4'd6;
   localparam logic [3:0] OP_STR  = 4'd7;
   localparam logic [3:0] OP_RTI  = 4'd8;
   localparam logic [3:0] OP_NOT  = 4'd9;
   localparam logic [3:0] OP_LDI  = 4'd10;
   localparam logic [3:0] OP_STI  = 4'd11;
   localparam logic [3:0] OP_JMP  = 4'd12;
   localparam logic [3:0] OP_RSVD = 4'd13;
   localparam logic [3:0] OP_LEA  = 4'd14;
   localparam logic [3:0] OP_TRAP = 4'd15;

   localparam logic [7:0] TRAP_GETC  = 8'h20;
   localparam logic [7:0] TRAP_OUT   = 8'h21;
   localparam logic [7:0] TRAP_PUTS  = 8'h22;
   localparam logic [7:0] TRAP_IN    = 8'h23;
   localparam logic [7:0] TRAP_PUTSP = 8'h24;
   localparam logic [7:0] TRAP_HALT  = 8'h25;

   typedef struct packed {
      logic [1:0]  run_status;
      logic [15:0] pc_now;
      logic        char_valid;
      logic [7:0]  out_char;
      logic [2:0]  flags_now;
      logic        string_busy;
   } rsp_type;

   function automatic logic [2:0] flags_of(input logic [15:0] v);
      logic [2:0] f;
      if (v == 16'd0) f = 3'b010;
      else if (v[15]) f = 3'b100;
      else f = 3'b001;
      return f;
   endfunction

endpackage

[design/lc3x_mem.sv]
// ----------------------------------------------------------------------------
// lc3x_mem
// Single-port word memory, registered read.
// ----------------------------------------------------------------------------
module lc3x_mem #(
   parameter int unsigned ADDR_BITS = lc3x_pkg::AddrBitsDefault
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] addr,
   input  logic [15:0]          wr_data,
   output logic [15:0]          rd_data
);
   logic [15:0] mem_ff [2**ADDR_BITS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

[design/lc3_instruction_execute_top.sv]
// ----------------------------------------------------------------------------
// lc3_instruction_execute_top
// LC-3 core driven one command beat at a time.
// ----------------------------------------------------------------------------
// A req_ beat carries a command: write one memory word, run one step, or
// restart at start_pc (set through csr_wen/csr_wdata while idle). Every
// command beat yields exactly one rsp_ beat reporting run status, PC, flags,
// an optional emitted character and whether a string is still in progress.
// One step runs one instruction or emits at most one character of a PUTS/PUTSP
// string. All memory traffic goes through a single-port synchronous memory.
// A write, restart, stopped step or pending PUTSP high byte passes S_FETCH and
// S_OUT; a string character adds S_STR, an instruction adds S_EXEC and S_DATA,
// LD/LDR/STI add S_IND, and LDI goes through S_IND again for the indirect word.
// The block then returns to idle, so no new beat is taken before the previous
// one is through. A new beat is taken once the block is idle and the output
// register is empty or its result is being taken; if the receiver stalls, the
// result waits there and no further beat is accepted. Reset (synchronous)
// clears registers, PC, flags and string state; memory content is undefined until written.
// ----------------------------------------------------------------------------
module lc3_instruction_execute_top #(
   parameter int unsigned ADDR_BITS = lc3x_pkg::AddrBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // cmd[1:0], mem_addr[17:2], mem_data[33:18],
                                    // key_char[41:34], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // run_status[1:0], pc_now[17:2], char_valid[18],
                                    // out_char[26:19], flags_now[29:27],
                                    // string_busy[30], zero pad
);
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_FETCH = 7'b0000010,
      S_EXEC  = 7'b0000100,
      S_IND   = 7'b0001000,
      S_DATA  = 7'b0010000,
      S_STR   = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic [15:0] start_pc_ff;
   logic [15:0] regs_ff [8];
   logic [15:0] pc_ff, pc_in;
   logic [2:0]  flags_ff, flags_in;
   logic [1:0]  run_ff, run_in;
   logic [1:0]  smode_ff, smode_in;
   logic [15:0] sptr_ff, sptr_in;
   logic [8:0]  pend_ff, pend_in;
   logic [15:0] ir_ff, ir_in;
   logic [1:0]  cmd_ff;
   logic [15:0] waddr_ff, wdata_ff;
   logic [7:0]  key_ff;
   logic        cv_ff, cv_in;
   logic [7:0]  ch_ff, ch_in;
   logic        rsp_v_ff;
   lc3x_pkg::rsp_type rsp_ff;

   logic        reg_we;
   logic [2:0]  reg_wa;
   logic [15:0] reg_wd;
   logic        set_flags;
   logic        link_we;

   logic        mem_we;
   logic [15:0] mem_a;
   logic [15:0] mem_wd, mem_rd;

   lc3x_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .addr    (mem_a[ADDR_BITS-1:0]),
      .wr_data (mem_wd),
      .rd_data (mem_rd)
   );

   // instruction decode
   logic [3:0]  op;
   logic [2:0]  dr, sr1;
   logic [15:0] pc1, off9, off6, off11, op2, base, ind_addr;
   assign op    = ir_ff[15:12];
   assign dr    = ir_ff[11:9];
   assign sr1   = ir_ff[8:6];
   assign pc1   = pc_ff + 16'd1;
   assign off9  = {{7{ir_ff[8]}}, ir_ff[8:0]};
   assign off6  = {{10{ir_ff[5]}}, ir_ff[5:0]};
   assign off11 = {{5{ir_ff[10]}}, ir_ff[10:0]};
   assign op2   = ir_ff[5] ? {{11{ir_ff[4]}}, ir_ff[4:0]} : regs_ff[ir_ff[2:0]];
   assign base  = regs_ff[sr1];
   assign ind_addr = (op == lc3x_pkg::OP_LDR || op == lc3x_pkg::OP_STR) ?
                     base + off6 : pc1 + off9;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_v_ff || rsp_tready);

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      flags_in  = flags_ff;
      run_in    = run_ff;
      smode_in  = smode_ff;
      sptr_in   = sptr_ff;
      pend_in   = pend_ff;
      ir_in     = ir_ff;
      cv_in     = cv_ff;
      ch_in     = ch_ff;
      reg_we    = 1'b0;
      reg_wa    = dr;
      reg_wd    = 16'd0;
      set_flags = 1'b0;
      link_we   = 1'b0;
      mem_we    = 1'b0;
      mem_a     = pc_ff;
      mem_wd    = regs_ff[dr];
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cv_in = 1'b0;
               ch_in = 8'd0;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            // dispatch the latched command
            state_in = S_OUT;
            case (cmd_ff)
               lc3x_pkg::CMD_WRITE: begin
                  mem_we = 1'b1;
                  mem_a  = waddr_ff;
                  mem_wd = wdata_ff;
               end
               lc3x_pkg::CMD_RESTART: begin
                  pc_in    = start_pc_ff;
                  run_in   = lc3x_pkg::RUN_GO;
                  smode_in = lc3x_pkg::STR_IDLE;
                  pend_in  = 9'd0;
               end
               lc3x_pkg::CMD_STEP: begin
                  if (run_ff == lc3x_pkg::RUN_GO) begin
                     if (pend_ff[8]) begin
                        cv_in   = 1'b1;
                        ch_in   = pend_ff[7:0];
                        pend_in = 9'd0;
                     end else if (smode_ff != lc3x_pkg::STR_IDLE) begin
                        mem_a    = sptr_ff;
                        sptr_in  = sptr_ff + 16'd1;
                        state_in = S_STR;
                     end else begin
                        mem_a    = pc_ff;
                        state_in = S_EXEC;
                     end
                  end
               end
               default: ;
            endcase
         end
         S_STR: begin
            state_in = S_OUT;
            if (mem_rd == 16'd0) begin
               smode_in = lc3x_pkg::STR_IDLE;
            end else begin
               cv_in = 1'b1;
               ch_in = mem_rd[7:0];
               if (smode_ff == lc3x_pkg::STR_PUTSP && mem_rd[15:8] != 8'd0) begin
                  pend_in = {1'b1, mem_rd[15:8]};
               end
            end
         end
         S_EXEC: begin
            ir_in    = mem_rd;
            state_in = S_DATA;
         end
         S_DATA: begin
            // ir_ff holds the instruction; pc_ff still the old PC
            state_in = S_OUT;
            pc_in    = pc1;
            case (op)
               lc3x_pkg::OP_BR: begin
                  if ((dr & flags_ff) != 3'd0) pc_in = pc1 + off9;
               end
               lc3x_pkg::OP_ADD: begin
                  reg_we = 1'b1; set_flags = 1'b1; reg_wd = base + op2;
               end
               lc3x_pkg::OP_AND: begin
                  reg_we = 1'b1; set_flags = 1'b1; reg_wd = base & op2;
               end
               lc3x_pkg::OP_NOT: begin
                  reg_we = 1'b1; set_flags = 1'b1; reg_wd = ~base;
               end
               lc3x_pkg::OP_LEA: begin
                  reg_we = 1'b1; set_flags = 1'b1; reg_wd = pc1 + off9;
               end
               lc3x_pkg::OP_JMP: pc_in = base;
               lc3x_pkg::OP_JSR: begin
                  reg_we = 1'b1; reg_wa = 3'd7; reg_wd = pc1;
                  pc_in  = ir_ff[11] ? pc1 + off11 : base;
               end
               lc3x_pkg::OP_ST, lc3x_pkg::OP_STR: begin
                  mem_we = 1'b1; mem_a = ind_addr;
               end
               lc3x_pkg::OP_LD, lc3x_pkg::OP_LDR, lc3x_pkg::OP_LDI,
               lc3x_pkg::OP_STI: begin
                  // read issued now; finish in S_IND (pc already advanced)
                  mem_a    = ind_addr;
                  ir_in    = ir_ff;
                  state_in = S_IND;
               end
               lc3x_pkg::OP_TRAP: begin
                  reg_we = 1'b1; reg_wa = 3'd7; reg_wd = pc1;
                  case (ir_ff[7:0])
                     lc3x_pkg::TRAP_GETC: begin
                        reg_wa = 3'd0; reg_wd = {8'd0, key_ff}; set_flags = 1'b1;
                        link_we = 1'b1;
                     end
                     lc3x_pkg::TRAP_IN: begin
                        reg_wa = 3'd0; reg_wd = {8'd0, key_ff}; set_flags = 1'b1;
                        link_we = 1'b1;
                        cv_in = 1'b1; ch_in = key_ff;
                     end
                     lc3x_pkg::TRAP_OUT: begin
                        cv_in = 1'b1; ch_in = regs_ff[0][7:0];
                     end
                     lc3x_pkg::TRAP_PUTS: begin
                        smode_in = lc3x_pkg::STR_PUTS; sptr_in = regs_ff[0];
                     end
                     lc3x_pkg::TRAP_PUTSP: begin
                        smode_in = lc3x_pkg::STR_PUTSP; sptr_in = regs_ff[0];
                     end
                     lc3x_pkg::TRAP_HALT: run_in = lc3x_pkg::RUN_HALTED;
                     default: ;
                  endcase
               end
               default: run_in = lc3x_pkg::RUN_INVALID;
            endcase
         end
         S_IND: begin
            // mem_rd holds the word at the effective address
            state_in = S_OUT;
            case (op)
               lc3x_pkg::OP_LD, lc3x_pkg::OP_LDR: begin
                  reg_we = 1'b1; set_flags = 1'b1; reg_wd = mem_rd;
               end
               lc3x_pkg::OP_LDI: begin
                  mem_a  = mem_rd;
                  ir_in  = {lc3x_pkg::OP_LD, ir_ff[11:0]};
                  state_in = S_IND;
               end
               default: begin
                  mem_we = 1'b1; mem_a = mem_rd;
               end
            endcase
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (reg_we && set_flags) begin
         flags_in = lc3x_pkg::flags_of(reg_wd);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         start_pc_ff <= lc3x_pkg::StartPcReset;
         pc_ff       <= 16'd0;
         flags_ff    <= 3'd0;
         run_ff      <= lc3x_pkg::RUN_GO;
         smode_ff    <= lc3x_pkg::STR_IDLE;
         sptr_ff     <= 16'd0;
         pend_ff     <= 9'd0;
         rsp_v_ff    <= 1'b0;
         for (int i = 0; i < 8; i++) regs_ff[i] <= 16'd0;
      end else begin
         if (csr_wen) start_pc_ff <= csr_wdata;
         state_ff <= state_in;
         pc_ff    <= pc_in;
         flags_ff <= flags_in;
         run_ff   <= run_in;
         smode_ff <= smode_in;
         sptr_ff  <= sptr_in;
         pend_ff  <= pend_in;
         // GETC and IN write R0 and the R7 link in the same cycle
         for (int i = 0; i < 8; i++) begin
            if (reg_we && reg_wa == 3'(i)) begin
               regs_ff[i] <= reg_wd;
            end else if (link_we && i == 7) begin
               regs_ff[i] <= pc1;
            end
         end
         if (state_ff == S_OUT) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ir_ff <= ir_in;
      cv_ff <= cv_in;
      ch_ff <= ch_in;
      if (req_tvalid && req_tready) begin
         cmd_ff   <= req_tdata[1:0];
         waddr_ff <= req_tdata[17:2];
         wdata_ff <= req_tdata[33:18];
         key_ff   <= req_tdata[41:34];
      end
      if (state_ff == S_OUT) begin
         rsp_ff.run_status  <= run_ff;
         rsp_ff.pc_now      <= pc_ff;
         rsp_ff.char_valid  <= cv_ff;
         rsp_ff.out_char    <= cv_ff ? ch_ff : 8'd0;
         rsp_ff.flags_now   <= flags_ff;
         rsp_ff.string_busy <= (smode_ff != lc3x_pkg::STR_IDLE) || pend_ff[8];
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.string_busy, rsp_ff.flags_now, rsp_ff.out_char,
                        rsp_ff.char_valid, rsp_ff.pc_now, rsp_ff.run_status};
endmodule
